// File: sv/pffc_pkg.sv
// Package for the PID controller with feed-forward and clamps.
// Holds the opcodes, register indexes, reset values and the structs
// passed between the front, the back and the queues. No dependencies.
package pffc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int JOB_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_COMPUTE = 2'd0,
    OP_RESET   = 2'd1,
    OP_ENABLE  = 2'd2,
    OP_DISABLE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_KP       = 3'd0,
    CFG_KI       = 3'd1,
    CFG_KD       = 3'd2,
    CFG_FF       = 3'd3,
    CFG_DRIVE_MAX = 3'd4,
    CFG_DRIVE_MIN = 3'd5,
    CFG_SUM_MAX  = 3'd6,
    CFG_SUM_MIN  = 3'd7
  } cfg_idx_t;

  localparam logic signed [31:0] KP_RST        = 32'sd65536;
  localparam logic signed [31:0] KI_RST        = 32'sd7;
  localparam logic signed [31:0] KD_RST        = 32'sd655360;
  localparam logic signed [31:0] FF_RST        = 32'sd0;
  localparam logic signed [31:0] DRIVE_MAX_RST = 32'sd2949120;
  localparam logic signed [31:0] DRIVE_MIN_RST = -32'sd2949120;
  localparam logic signed [31:0] SUM_MAX_RST   = 32'sd65536000;
  localparam logic signed [31:0] SUM_MIN_RST   = -32'sd65536000;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] kp;
    logic signed [31:0] ki;
    logic signed [31:0] kd;
    logic signed [31:0] ff;
    logic signed [31:0] drive_max;
    logic signed [31:0] drive_min;
    logic signed [31:0] sum_max;
    logic signed [31:0] sum_min;
  } cfg_t;

  typedef struct packed {
    logic               run;
    logic signed [31:0] err;
    logic signed [31:0] sum;
    logic signed [31:0] delta;
    logic signed [31:0] target;
    logic               sclamp;
    logic               active;
  } job_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] error_sum;
    logic signed [31:0] error_delta;
    logic               sum_clamped;
    logic               drive_clamped;
    logic               active;
  } res_t;

endpackage

// File: sv/pffc_fifo.sv
// Small first-in first-out queue of register entries.
// Used between front and back and as the result queue; no package use.
module pffc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;
  logic [AW:0]      cnt;
  logic             do_wr;
  logic             do_rd;

  assign full  = cnt == (AW+1)'(DEPTH);
  assign empty = cnt == '0;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (do_rd) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - (AW+1)'(1);
      end
    end
  end

endmodule

// File: sv/pffc_front.sv
// Front part: accepts items, updates the error sum, previous error and
// enable state, and queues a job for the back part. Uses pffc_pkg.
module pffc_front (
  input  logic               clk,
  input  logic               rst,
  input  pffc_pkg::cfg_t     cfg,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] target,
  input  logic signed [31:0] measured,
  output logic               job_wr,
  output pffc_pkg::job_t     job
);
  import pffc_pkg::*;

  logic signed [31:0] sum_reg;
  logic signed [31:0] prev_error;
  logic               enabled_flag;
  logic signed [31:0] sum_reg_next;
  logic signed [31:0] prev_error_next;
  logic               enabled_flag_next;

  logic signed [32:0] diff;
  logic signed [31:0] err;
  logic signed [32:0] raw;
  logic signed [32:0] hi_lim;
  logic signed [32:0] lo_lim;
  logic signed [32:0] v1;
  logic signed [32:0] v2;
  logic signed [32:0] ddiff;
  logic signed [31:0] delta;
  logic               run;

  assign job_wr = push && !full;

  always_comb begin
    diff = {target[31], target} - {measured[31], measured};
    if (diff[32] != diff[31]) begin
      err = diff[32] ? S32_MIN : S32_MAX;
    end else begin
      err = diff[31:0];
    end
    raw    = {sum_reg[31], sum_reg} + {err[31], err};
    hi_lim = {cfg.sum_max[31], cfg.sum_max};
    lo_lim = {cfg.sum_min[31], cfg.sum_min};
    v1     = (raw > hi_lim) ? hi_lim : raw;
    v2     = (v1 < lo_lim) ? lo_lim : v1;
    ddiff  = {err[31], err} - {prev_error[31], prev_error};
    if (ddiff[32] != ddiff[31]) begin
      delta = ddiff[32] ? S32_MIN : S32_MAX;
    end else begin
      delta = ddiff[31:0];
    end

    sum_reg_next      = sum_reg;
    prev_error_next   = prev_error;
    enabled_flag_next = enabled_flag;
    run               = 1'b0;
    case (op_t'(opcode))
      OP_COMPUTE: begin
        if (enabled_flag) begin
          run             = 1'b1;
          sum_reg_next    = v2[31:0];
          prev_error_next = err;
        end
      end
      OP_RESET: begin
        sum_reg_next    = '0;
        prev_error_next = '0;
      end
      OP_ENABLE: begin
        if (!enabled_flag) begin
          sum_reg_next    = '0;
          prev_error_next = '0;
        end
        enabled_flag_next = 1'b1;
      end
      OP_DISABLE: begin
        enabled_flag_next = 1'b0;
      end
      default: begin
        enabled_flag_next = enabled_flag;
      end
    endcase

    job.run    = run;
    job.err    = err;
    job.sum    = sum_reg_next;
    job.delta  = run ? delta : '0;
    job.target = target;
    job.sclamp = run && (v2 != raw);
    job.active = enabled_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_reg      <= '0;
      prev_error   <= '0;
      enabled_flag <= 1'b1;
    end else if (job_wr) begin
      sum_reg      <= sum_reg_next;
      prev_error   <= prev_error_next;
      enabled_flag <= enabled_flag_next;
    end
  end

endmodule

// File: sv/pffc_back.sv
// Back part: forms the four gain products on one shared multiplier,
// accumulates them, clamps the drive and writes the result queue.
// Uses pffc_pkg.
module pffc_back #(
  parameter int FRAC_BITS = pffc_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  pffc_pkg::cfg_t cfg,
  input  logic           job_empty,
  input  pffc_pkg::job_t job,
  output logic           job_pop,
  input  logic           res_full,
  output logic           res_wr,
  output pffc_pkg::res_t res
);
  import pffc_pkg::*;

  localparam int TOT_W = 64 - FRAC_BITS + 2;

  logic               busy;
  logic [1:0]         cnt;
  logic               tail;
  job_t               cur;
  job_t               tinfo;
  logic signed [63:0] prod;
  logic signed [TOT_W-1:0] acc;

  logic               advance;
  logic               last;
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [63:0] prod_next;
  logic signed [TOT_W-1:0] term;
  logic signed [TOT_W-1:0] total;
  logic signed [TOT_W-1:0] dmax;
  logic signed [TOT_W-1:0] dmin;
  logic signed [TOT_W-1:0] d1;
  logic signed [TOT_W-1:0] d2;

  assign advance = !(tail && res_full);
  assign last    = busy && (cnt == 2'd3);
  assign job_pop = advance && (!busy || last) && !job_empty;
  assign res_wr  = tail && advance;

  always_comb begin
    case (cnt)
      2'd0: begin
        op_a = cfg.kp;
        op_b = cur.err;
      end
      2'd1: begin
        op_a = cfg.ki;
        op_b = cur.sum;
      end
      2'd2: begin
        op_a = cfg.kd;
        op_b = cur.delta;
      end
      2'd3: begin
        op_a = cfg.ff;
        op_b = cur.target;
      end
      default: begin
        op_a = cfg.kp;
        op_b = cur.err;
      end
    endcase
    prod_next = op_a * op_b;
    term      = TOT_W'(prod >>> FRAC_BITS);
    total     = acc + term;
    dmax      = TOT_W'(cfg.drive_max);
    dmin      = TOT_W'(cfg.drive_min);
    d1        = (total > dmax) ? dmax : total;
    d2        = (d1 < dmin) ? dmin : d1;

    res.drive         = tinfo.run ? d2[31:0] : '0;
    res.drive_clamped = tinfo.run && (d2 != total);
    res.error_sum     = tinfo.sum;
    res.error_delta   = tinfo.delta;
    res.sum_clamped   = tinfo.sclamp;
    res.active        = tinfo.active;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      tail <= 1'b0;
    end else if (advance) begin
      tail <= last;
      if (busy) begin
        cnt <= cnt + 2'd1;
        if (last) begin
          busy <= 1'b0;
        end
      end
      if (job_pop) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (last) begin
        tinfo <= cur;
      end
      if (job_pop) begin
        cur <= job;
      end
      if (busy) begin
        prod <= prod_next;
        acc  <= (cnt == 2'd0) ? '0 : total;
      end
    end
  end

endmodule

// File: sv/pid_ff_clamped_controller.sv
// Top level of the PID controller with feed-forward and clamps: holds the
// gain and limit registers and joins front, job queue, back and result
// queue. Uses pffc_pkg, pffc_front, pffc_fifo and pffc_back.
//
//   channel   handshake          payload
//   input     push / full        opcode, target, measured
//   result    empty / pop        drive, error_sum, error_delta,
//                                sum_clamped, drive_clamped, active
//   config    cfg_wr             cfg_index, cfg_data
//
// Each item forms its four products in turn on the shared 32x32 multiplier,
// and the back takes the next job while the last product of the current
// one is formed. The front takes an item per cycle until the two-entry job
// queue fills. A full result queue stalls only the back. Reset is
// synchronous and restores the register defaults and the controller state.
module pid_ff_clamped_controller #(
  parameter int FRAC_BITS = pffc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] target,
  input  logic signed [31:0] measured,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] drive,
  output logic signed [31:0] error_sum,
  output logic signed [31:0] error_delta,
  output logic               sum_clamped,
  output logic               drive_clamped,
  output logic               active,
  input  logic               cfg_wr,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import pffc_pkg::*;

  cfg_t cfg;
  logic job_wr;
  job_t job_in;
  logic job_empty;
  job_t job_out;
  logic job_pop;
  logic res_full;
  logic res_wr;
  res_t res_in;
  res_t res_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp        <= KP_RST;
      cfg.ki        <= KI_RST;
      cfg.kd        <= KD_RST;
      cfg.ff        <= FF_RST;
      cfg.drive_max <= DRIVE_MAX_RST;
      cfg.drive_min <= DRIVE_MIN_RST;
      cfg.sum_max   <= SUM_MAX_RST;
      cfg.sum_min   <= SUM_MIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KP:        cfg.kp        <= cfg_data;
        CFG_KI:        cfg.ki        <= cfg_data;
        CFG_KD:        cfg.kd        <= cfg_data;
        CFG_FF:        cfg.ff        <= cfg_data;
        CFG_DRIVE_MAX: cfg.drive_max <= cfg_data;
        CFG_DRIVE_MIN: cfg.drive_min <= cfg_data;
        CFG_SUM_MAX:   cfg.sum_max   <= cfg_data;
        CFG_SUM_MIN:   cfg.sum_min   <= cfg_data;
        default:       cfg.kp        <= cfg.kp;
      endcase
    end
  end

  pffc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .opcode   (opcode),
    .target   (target),
    .measured (measured),
    .job_wr   (job_wr),
    .job      (job_in)
  );

  pffc_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (job_wr),
    .wdata (job_in),
    .full  (full),
    .rd    (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  pffc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res       (res_in)
  );

  pffc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_wr),
    .wdata (res_in),
    .full  (res_full),
    .rd    (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign drive         = res_out.drive;
  assign error_sum     = res_out.error_sum;
  assign error_delta   = res_out.error_delta;
  assign sum_clamped   = res_out.sum_clamped;
  assign drive_clamped = res_out.drive_clamped;
  assign active        = res_out.active;

  a_pop_has_job: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !job_empty)
    else $error("Back took a job from an empty queue.");

  a_wr_has_room: assert property (@(posedge clk) disable iff (rst)
    res_wr |-> !res_full)
    else $error("Result written into a full queue.");

  a_inactive_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !active) |-> (drive == '0 && !drive_clamped && error_delta == '0))
    else $error("Disabled controller produced a nonzero drive.");

  a_clamp_at_limit: assert property (@(posedge clk) disable iff (rst)
    (!empty && drive_clamped) |-> (drive == cfg.drive_max || drive == cfg.drive_min))
    else $error("Clamped drive is not at a limit.");

endmodule

// File: test/tb_pid_ff_clamped_controller.sv
// Self-checking testbench for pid_ff_clamped_controller: a directed table, then random
// phases under different gain and limit settings, checked against an in-bench predictor.
// Depends on pffc_pkg and the controller RTL only.
module tb_pid_ff_clamped_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import pffc_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int LONG_HOLD = 120;
  localparam int DRAIN_CYCLES = 20;
  localparam int N_PLAN = 26;

  typedef struct {
    logic               is_reg;
    op_t                op;
    cfg_idx_t           idx;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               typed;
    logic               act;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         opcode = OP_COMPUTE;
  logic signed [31:0] target = '0;
  logic signed [31:0] measured = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [31:0] drive;
  logic signed [31:0] error_sum;
  logic signed [31:0] error_delta;
  logic               sum_clamped;
  logic               drive_clamped;
  logic               active;
  logic               cfg_wr = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  logic signed [31:0] gain_q [8] = '{KP_RST, KI_RST, KD_RST, FF_RST,
                                     DRIVE_MAX_RST, DRIVE_MIN_RST, SUM_MAX_RST, SUM_MIN_RST};
  logic signed [31:0] sum_st = '0;
  logic signed [31:0] perr_st = '0;
  logic               en_st = 1'b1;

  res_t due_results [$];
  int   seen = 0;
  int   fails = 0;
  bit   calm = 1'b0;
  bit   holding = 1'b0;

  // Special cases: disabled compute, enable while off and on, saturated error and delta,
  // crossed limits for the sum and the drive, and extreme gains.
  plan_row_t plan [N_PLAN] = '{
    '{1'b0, OP_DISABLE, CFG_KP, 32'sd0, 32'sd0, 1'b1, 1'b0},
    '{1'b0, OP_COMPUTE, CFG_KP, 32'sd5, 32'sd3, 1'b1, 1'b0},
    '{1'b0, OP_ENABLE, CFG_KP, 32'sd0, 32'sd0, 1'b1, 1'b1},
    '{1'b0, OP_COMPUTE, CFG_KP, 32'sd0, 32'sd0, 1'b1, 1'b1},
    '{1'b0, OP_COMPUTE, CFG_KP, 32'sh0001_0000, 32'sd0, 1'b0, 1'b0},
    '{1'b0, OP_COMPUTE, CFG_KP, S32_MAX, S32_MIN, 1'b0, 1'b0},
    '{1'b0, OP_COMPUTE, CFG_KP, S32_MIN, S32_MAX, 1'b0, 1'b0},
    '{1'b0, OP_COMPUTE, CFG_KP, -32'sd1, 32'sd0, 1'b0, 1'b0},
    '{1'b0, OP_RESET, CFG_KP, S32_MIN, S32_MAX, 1'b1, 1'b1},
    '{1'b0, OP_COMPUTE, CFG_KP, 32'sh0003_0000, 32'sh0001_0000, 1'b0, 1'b0},
    '{1'b0, OP_ENABLE, CFG_KP, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{1'b0, OP_COMPUTE, CFG_KP, 32'sh0002_8000, 32'sh0001_0000, 1'b0, 1'b0},
    '{1'b0, OP_DISABLE, CFG_KP, 32'sd0, 32'sd0, 1'b0, 1'b0},
    '{1'b0, OP_COMPUTE, CFG_KP, 32'sh1234_5678, -32'sd77, 1'b0, 1'b0},
    '{1'b0, OP_ENABLE, CFG_KP, 32'sd0, 32'sd0, 1'b1, 1'b1},
    '{1'b1, OP_COMPUTE, CFG_DRIVE_MAX, -32'sh0001_0000, 32'sd0, 1'b0, 1'b0},
    '{1'b1, OP_COMPUTE, CFG_DRIVE_MIN, 32'sh0001_0000, 32'sd0, 1'b0, 1'b0},
    '{1'b1, OP_COMPUTE, CFG_SUM_MAX, -32'sh0002_0000, 32'sd0, 1'b0, 1'b0},
    '{1'b1, OP_COMPUTE, CFG_SUM_MIN, 32'sh0002_0000, 32'sd0, 1'b0, 1'b0},
    '{1'b1, OP_COMPUTE, CFG_FF, 32'sh0001_0000, 32'sd0, 1'b0, 1'b0},
    '{1'b0, OP_COMPUTE, CFG_KP, 32'sh0005_0000, 32'sh0001_0000, 1'b0, 1'b0},
    '{1'b0, OP_COMPUTE, CFG_KP, S32_MIN, 32'sd0, 1'b0, 1'b0},
    '{1'b1, OP_COMPUTE, CFG_KP, S32_MIN, 32'sd0, 1'b0, 1'b0},
    '{1'b1, OP_COMPUTE, CFG_KI, S32_MAX, 32'sd0, 1'b0, 1'b0},
    '{1'b1, OP_COMPUTE, CFG_KD, S32_MIN, 32'sd0, 1'b0, 1'b0},
    '{1'b0, OP_COMPUTE, CFG_KP, S32_MAX, S32_MIN, 1'b0, 1'b0}
  };

  pid_ff_clamped_controller DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .opcode(opcode), .target(target), .measured(measured),
    .empty(empty), .pop(pop), .drive(drive), .error_sum(error_sum),
    .error_delta(error_delta), .sum_clamped(sum_clamped),
    .drive_clamped(drive_clamped), .active(active),
    .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint clip32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // The upper limit is applied first, so crossed limits give the lower one.
  function automatic longint bound(longint v, longint lo, longint hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic res_t predict_pid_step(op_t op, logic signed [31:0] tgt,
                                            logic signed [31:0] meas);
    res_t   r;
    longint err;
    longint raw;
    longint nsum;
    longint dlt;
    longint tot;
    longint ndrv;
    r = '0;
    case (op)
      OP_COMPUTE: begin
        if (en_st) begin
          err  = clip32(longint'(tgt) - longint'(meas));
          raw  = longint'(sum_st) + err;
          nsum = bound(raw, gain_q[CFG_SUM_MIN], gain_q[CFG_SUM_MAX]);
          dlt  = clip32(err - longint'(perr_st));
          tot  = ((longint'(gain_q[CFG_KP]) * err) >>> FRAC)
               + ((longint'(gain_q[CFG_KI]) * nsum) >>> FRAC)
               + ((longint'(gain_q[CFG_KD]) * dlt) >>> FRAC)
               + ((longint'(gain_q[CFG_FF]) * longint'(tgt)) >>> FRAC);
          ndrv = bound(tot, gain_q[CFG_DRIVE_MIN], gain_q[CFG_DRIVE_MAX]);
          r.drive = ndrv[31:0];
          r.error_delta = dlt[31:0];
          r.sum_clamped = (nsum != raw);
          r.drive_clamped = (ndrv != tot);
          sum_st = nsum[31:0];
          perr_st = err[31:0];
        end
      end
      OP_RESET: begin
        sum_st = '0;
        perr_st = '0;
      end
      OP_ENABLE: begin
        if (!en_st) begin
          sum_st = '0;
          perr_st = '0;
        end
        en_st = 1'b1;
      end
      default: begin
        en_st = 1'b0;
      end
    endcase
    r.error_sum = sum_st;
    r.active = en_st;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic logic signed [31:0] sym(int unsigned m);
    return int'($urandom_range(0, 2 * m)) - int'(m);
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return pick_extreme();
      1, 2: return $urandom;
      default: return sym(32'h0010_0000);
    endcase
  endfunction

  task automatic offer(input op_t op, input logic signed [31:0] tgt,
                       input logic signed [31:0] meas, output res_t pred);
    push <= 1'b1;
    opcode <= op;
    target <= tgt;
    measured <= meas;
    @(posedge clk);
    while (full) @(posedge clk);
    pred = predict_pid_step(op, tgt, meas);
  endtask

  task automatic maybe_gap();
    if (!calm && !holding && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic signed [31:0] v);
    cfg_wr <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    gain_q[idx] = v;
    @(posedge clk);
  endtask

  task automatic program_phase(input int p);
    logic signed [31:0] v [8];
    case (p % 4)
      0: begin
        v[CFG_KP] = sym(1 << 18);
        v[CFG_KI] = sym(1 << 12);
        v[CFG_KD] = sym(1 << 18);
        v[CFG_FF] = sym(1 << 17);
        v[CFG_DRIVE_MAX] = $urandom_range(0, 1 << 26);
        v[CFG_DRIVE_MIN] = -int'($urandom_range(0, 1 << 26));
        v[CFG_SUM_MAX] = $urandom_range(0, 1 << 24);
        v[CFG_SUM_MIN] = -int'($urandom_range(0, 1 << 24));
      end
      1: begin
        foreach (v[i]) v[i] = pick_extreme();
        if (p == 1) begin
          v[CFG_DRIVE_MAX] = S32_MAX;
          v[CFG_DRIVE_MIN] = S32_MIN;
          v[CFG_SUM_MAX] = S32_MAX;
          v[CFG_SUM_MIN] = S32_MIN;
        end
      end
      2: begin
        v[CFG_KP] = sym(1 << 18);
        v[CFG_KI] = sym(1 << 12);
        v[CFG_KD] = sym(1 << 18);
        v[CFG_FF] = sym(1 << 17);
        v[CFG_DRIVE_MAX] = -int'($urandom_range(0, 1 << 20));
        v[CFG_DRIVE_MIN] = $urandom_range(0, 1 << 20);
        v[CFG_SUM_MAX] = -int'($urandom_range(0, 1 << 22));
        v[CFG_SUM_MIN] = $urandom_range(0, 1 << 22);
      end
      default: begin
        foreach (v[i]) v[i] = $urandom;
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), v[i]);
    cfg_wr <= 1'b0;
  endtask

  task automatic check_result();
    res_t got;
    res_t want;
    got = {drive, error_sum, error_delta, sum_clamped, drive_clamped, active};
    seen++;
    if (due_results.size() == 0) begin
      fails++;
      if (fails <= 10) $display("result %0d arrived with nothing expected", seen);
    end else begin
      want = due_results.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10) begin
          $display("result %0d: expected drive=%0d sum=%0d delta=%0d sc=%0b dc=%0b act=%0b",
                   seen, want.drive, want.error_sum, want.error_delta,
                   want.sum_clamped, want.drive_clamped, want.active);
          $display("result %0d: got      drive=%0d sum=%0d delta=%0d sc=%0b dc=%0b act=%0b",
                   seen, got.drive, got.error_sum, got.error_delta,
                   got.sum_clamped, got.drive_clamped, got.active);
        end
      end
    end
  endtask

  // Result side: random pop bursts, plus one long hold so the input backs up.
  initial begin
    int hold;
    bit long_done;
    hold = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) check_result();
      if (rst) begin
        pop <= 1'b0;
      end else if (!long_done && seen >= 300) begin
        long_done = 1'b1;
        holding = 1'b1;
        hold = LONG_HOLD;
        pop <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        if (hold == 0) holding = 1'b0;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(0, 14);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    res_t               pred;
    op_t                op;
    logic signed [31:0] tgt;
    logic signed [31:0] meas;
    int                 r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_PLAN; i++) begin
      if (plan[i].is_reg) begin
        if (i == 0 || !plan[i - 1].is_reg) settle();
        write_reg(plan[i].idx, plan[i].a);
        if (i + 1 == N_PLAN || !plan[i + 1].is_reg) cfg_wr <= 1'b0;
      end else begin
        offer(plan[i].op, plan[i].a, plan[i].b, pred);
        if (plan[i].typed) begin
          pred = '0;
          pred.active = plan[i].act;
        end
        due_results.push_back(pred);
        maybe_gap();
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      program_phase(p);
      calm = (p == N_PHASES - 1);
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        op = (r < 82) ? OP_COMPUTE : (r < 88) ? OP_RESET : (r < 96) ? OP_ENABLE : OP_DISABLE;
        tgt = rand_word();
        meas = $urandom_range(0, 1) ? tgt + sym(1 << 18) : rand_word();
        offer(op, tgt, meas, pred);
        due_results.push_back(pred);
        maybe_gap();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && due_results.size() == 0) begin
      $display("tb_pid_ff_clamped_controller: PASS");
    end else begin
      $display("tb_pid_ff_clamped_controller: FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb_pid_ff_clamped_controller: FAIL");
    $finish;
  end

endmodule

// File: files.f
sv/pffc_pkg.sv
sv/pffc_fifo.sv
sv/pffc_front.sv
sv/pffc_back.sv
sv/pid_ff_clamped_controller.sv
test/tb_pid_ff_clamped_controller.sv
